FILE: hdl/lfps_pkg.sv
// Shared types, widths, codes and reset values for the line-follow PID steering block.
package lfps_pkg;

    // Field and datapath widths
    localparam int SENS_W  = 8;
    localparam int CAM_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int SPD_W   = 8;
    localparam int LIM_W   = 15;
    localparam int POS_W   = 12;
    localparam int DLT_W   = 13;
    localparam int INT_W   = 32;
    localparam int TERM_W  = 34;
    localparam int ACC_W   = 58;
    localparam int WQ_W    = ACC_W + 1 - 16;
    localparam int OUT_W   = 9;
    localparam int DIR_W   = 2;
    localparam int CNT_W   = 4;
    localparam int HS_W    = 8;
    localparam int WGT_W   = 6;
    localparam int DIV_W   = 15;
    localparam int DIV_CW  = 4;
    localparam int REM_W   = 5;
    localparam int MAC_CW  = 5;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    // Serial step counts
    localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_W - 1);
    localparam logic [MAC_CW-1:0] MAC_LAST = MAC_CW'(GAIN_W);

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_PROP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_INTEG = 3'd1;
    localparam logic [IDX_W-1:0] REG_DERIV = 3'd2;
    localparam logic [IDX_W-1:0] REG_FAST  = 3'd3;
    localparam logic [IDX_W-1:0] REG_SLOW  = 3'd4;
    localparam logic [IDX_W-1:0] REG_LIMIT = 3'd5;

    // Register reset values
    localparam logic [GAIN_W-1:0] PROP_RST  = 24'd6400;
    localparam logic [GAIN_W-1:0] INTEG_RST = 24'd3;
    localparam logic [GAIN_W-1:0] DERIV_RST = 24'd1280;
    localparam logic [SPD_W-1:0]  FAST_RST  = 8'd80;
    localparam logic [SPD_W-1:0]  SLOW_RST  = 8'd50;
    localparam logic [LIM_W-1:0]  LIMIT_RST = 15'd30;

    // Drive direction codes
    localparam logic [DIR_W-1:0] DIR_FWD   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;

    // Last side codes
    localparam logic [1:0] SIDE_CTR   = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    // Speed limits
    localparam logic signed [OUT_W-1:0] CORNER_SPEED = 9'sd50;
    localparam logic signed [OUT_W-1:0] SPD_POS_MAX  = 9'sd255;
    localparam logic signed [OUT_W-1:0] SPD_NEG_MAX  = -9'sd255;
    localparam logic signed [WQ_W-1:0]  WQ_POS_MAX   = 43'sd255;
    localparam logic signed [WQ_W-1:0]  WQ_NEG_MAX   = -43'sd255;

    // Configuration register set
    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [SPD_W-1:0]  fast_speed;
        logic [SPD_W-1:0]  slow_speed;
        logic [LIM_W-1:0]  camera_limit;
    } t_cfg;

    // Position unit status
    typedef struct packed {
        logic                    done;
        logic                    seen;
        logic signed [POS_W-1:0] pos;
    } t_pos_stat;

    // Position unit phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SCAN,
        PH_PREP,
        PH_DIV,
        PH_DONE
    } t_pos_phase;

    // Top level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_UPD,
        ST_MAC,
        ST_WHL,
        ST_WHR,
        ST_OUT
    } t_state;

endpackage

FILE: hdl/line_follow_pid_steering.sv
// Top level of the line-follow PID steering block.
// A word with the line seen passes the sensor scan, the 15-step divider, the 25-step serial
// MAC and the left and right wheel states; with no line, the divider and MAC are skipped.
// One word is in work at a time; the next is taken the cycle after the result is loaded
// into the output register, even if it is stalled.
// Reset (synchronous, active low) clears the integral, previous position and last side.
module line_follow_pid_steering #(
    parameter int SENSOR_COUNT = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [lfps_pkg::SENS_W-1:0]        i_sensor_bits,
    input  logic signed [lfps_pkg::CAM_W-1:0]  i_camera_error,
    input  logic                               i_camera_ok,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [lfps_pkg::DIR_W-1:0]         o_drive_dir,
    output logic signed [lfps_pkg::OUT_W-1:0]  o_left_speed,
    output logic signed [lfps_pkg::OUT_W-1:0]  o_right_speed,
    output logic                               o_line_seen,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lfps_pkg::ADDR_W-1:0]        paddr,
    input  logic [lfps_pkg::DATA_W-1:0]        pwdata,
    output logic [lfps_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int XW = lfps_pkg::ACC_W + 1;

    lfps_pkg::t_state    r_state, n_state;
    lfps_pkg::t_cfg      w_cfg;
    lfps_pkg::t_pos_stat w_pos;

    logic w_accept;
    logic w_mac_start;
    logic w_mac_done;
    logic w_out_load;

    logic signed [lfps_pkg::POS_W-1:0]  r_pos;
    logic signed [lfps_pkg::POS_W-1:0]  r_prev;
    logic signed [lfps_pkg::INT_W-1:0]  r_integ;
    logic signed [lfps_pkg::DLT_W-1:0]  r_delta;
    logic [1:0]                         r_side;
    logic [lfps_pkg::SPD_W-1:0]         r_base;
    logic [lfps_pkg::DIR_W-1:0]         r_dir;
    logic signed [lfps_pkg::OUT_W-1:0]  r_left;
    logic signed [lfps_pkg::OUT_W-1:0]  r_right;
    logic                               r_seen;

    logic                               r_oval;
    logic [lfps_pkg::DIR_W-1:0]         r_odir;
    logic signed [lfps_pkg::OUT_W-1:0]  r_oleft;
    logic signed [lfps_pkg::OUT_W-1:0]  r_oright;
    logic                               r_oseen;

    logic signed [lfps_pkg::ACC_W-1:0]  w_acc;
    logic signed [16:0]                 w_cam;
    logic signed [16:0]                 w_lim;
    logic                               w_fast;
    logic [lfps_pkg::INT_W:0]           w_isum;
    logic [lfps_pkg::INT_W-1:0]         w_inext;
    logic [XW-1:0]                      w_bias;
    logic [XW-1:0]                      w_accx;
    logic [XW-1:0]                      w_x;
    logic signed [lfps_pkg::WQ_W-1:0]   w_q;
    logic signed [lfps_pkg::OUT_W-1:0]  w_wheel;

    // Configuration registers
    lfps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Line position
    lfps_pos #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_accept),
        .i_sensor_bits (i_sensor_bits),
        .o_stat        (w_pos)
    );

    // PID correction
    lfps_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mac_start),
        .i_cfg   (w_cfg),
        .i_pos   (r_pos),
        .i_integ (r_integ),
        .i_delta (r_delta),
        .o_done  (w_mac_done),
        .o_acc   (w_acc)
    );

    // Sequence one word through the units
    always_comb begin
        case (r_state)
            lfps_pkg::ST_IDLE: n_state = w_accept ? lfps_pkg::ST_POS : lfps_pkg::ST_IDLE;
            lfps_pkg::ST_POS: begin
                if (!w_pos.done) begin
                    n_state = lfps_pkg::ST_POS;
                end else if (w_pos.seen) begin
                    n_state = lfps_pkg::ST_UPD;
                end else begin
                    n_state = lfps_pkg::ST_OUT;
                end
            end
            lfps_pkg::ST_UPD: n_state = lfps_pkg::ST_MAC;
            lfps_pkg::ST_MAC: n_state = w_mac_done ? lfps_pkg::ST_WHL : lfps_pkg::ST_MAC;
            lfps_pkg::ST_WHL: n_state = lfps_pkg::ST_WHR;
            lfps_pkg::ST_WHR: n_state = lfps_pkg::ST_OUT;
            lfps_pkg::ST_OUT: n_state = w_out_load ? lfps_pkg::ST_IDLE : lfps_pkg::ST_OUT;
            default:          n_state = lfps_pkg::ST_IDLE;
        endcase
    end

    // Drive handshake and unit controls from the state
    always_comb begin
        o_stall     = (r_state != lfps_pkg::ST_IDLE);
        w_accept    = i_valid && (r_state == lfps_pkg::ST_IDLE);
        w_mac_start = (r_state == lfps_pkg::ST_UPD);
        w_out_load  = (r_state == lfps_pkg::ST_OUT) && (!r_oval || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pick the base speed from the camera error
    assign w_cam  = {i_camera_error[lfps_pkg::CAM_W-1], i_camera_error};
    assign w_lim  = {2'b00, w_cfg.camera_limit};
    assign w_fast = i_camera_ok && (w_cam < w_lim) && (w_cam > -w_lim);

    // Saturating integral update
    assign w_isum  = {r_integ[lfps_pkg::INT_W-1], r_integ}
                   + {{(lfps_pkg::INT_W + 1 - lfps_pkg::POS_W){r_pos[lfps_pkg::POS_W-1]}}, r_pos};
    assign w_inext = (w_isum[lfps_pkg::INT_W] == w_isum[lfps_pkg::INT_W-1])
                   ? w_isum[lfps_pkg::INT_W-1:0]
                   : {w_isum[lfps_pkg::INT_W], {(lfps_pkg::INT_W - 1){~w_isum[lfps_pkg::INT_W]}}};

    // Wheel value: base*65536 + 0.5 minus (left) or plus (right) the sum, floored
    assign w_bias  = {{(XW - 24){1'b0}}, r_base, 16'h8000};
    assign w_accx  = {w_acc[lfps_pkg::ACC_W-1], w_acc};
    assign w_x     = (r_state == lfps_pkg::ST_WHL) ? (w_bias - w_accx) : (w_bias + w_accx);
    assign w_q     = w_x[XW-1:16];
    assign w_wheel = (w_q > lfps_pkg::WQ_POS_MAX) ? lfps_pkg::SPD_POS_MAX
                   : (w_q < lfps_pkg::WQ_NEG_MAX) ? lfps_pkg::SPD_NEG_MAX
                   : w_q[lfps_pkg::OUT_W-1:0];

    // Hold the PID state and last side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
            r_side  <= lfps_pkg::SIDE_CTR;
        end else if (r_state == lfps_pkg::ST_UPD) begin
            r_integ <= w_inext;
            r_prev  <= r_pos;
            if (r_pos < 0) begin
                r_side <= lfps_pkg::SIDE_LEFT;
            end else if (r_pos > 0) begin
                r_side <= lfps_pkg::SIDE_RIGHT;
            end else begin
                r_side <= lfps_pkg::SIDE_CTR;
            end
        end
    end

    // Build the result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base <= w_fast ? w_cfg.fast_speed : w_cfg.slow_speed;
        end
        case (r_state)
            lfps_pkg::ST_POS: begin
                if (w_pos.done) begin
                    r_pos  <= w_pos.pos;
                    r_seen <= w_pos.seen;
                    r_dir  <= w_pos.seen ? lfps_pkg::DIR_FWD
                            : (r_side == lfps_pkg::SIDE_LEFT) ? lfps_pkg::DIR_LEFT
                                                              : lfps_pkg::DIR_RIGHT;
                    r_left  <= lfps_pkg::CORNER_SPEED;
                    r_right <= lfps_pkg::CORNER_SPEED;
                end
            end
            lfps_pkg::ST_UPD: r_delta <= {r_pos[lfps_pkg::POS_W-1], r_pos}
                                       - {r_prev[lfps_pkg::POS_W-1], r_prev};
            lfps_pkg::ST_WHL: r_left  <= w_wheel;
            lfps_pkg::ST_WHR: r_right <= w_wheel;
            default: ;
        endcase
    end

    // Output register: load when empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (w_out_load) begin
            r_oval <= 1'b1;
        end else if (!i_stall) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_odir   <= r_dir;
            r_oleft  <= r_left;
            r_oright <= r_right;
            r_oseen  <= r_seen;
        end
    end

    assign o_valid       = r_oval;
    assign o_drive_dir   = r_odir;
    assign o_left_speed  = r_oleft;
    assign o_right_speed = r_oright;
    assign o_line_seen   = r_oseen;

endmodule

FILE: hdl/lfps_regs.sv
// Configuration register file behind the APB-style port.
module lfps_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfps_pkg::ADDR_W-1:0] paddr,
    input  logic [lfps_pkg::DATA_W-1:0] pwdata,
    output logic [lfps_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output lfps_pkg::t_cfg              o_cfg
);

    lfps_pkg::t_cfg               r_cfg;
    logic [lfps_pkg::IDX_W-1:0]   w_idx;
    logic                         w_wr;

    assign w_idx  = paddr[lfps_pkg::ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write the addressed register in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain    <= lfps_pkg::PROP_RST;
            r_cfg.integ_gain   <= lfps_pkg::INTEG_RST;
            r_cfg.deriv_gain   <= lfps_pkg::DERIV_RST;
            r_cfg.fast_speed   <= lfps_pkg::FAST_RST;
            r_cfg.slow_speed   <= lfps_pkg::SLOW_RST;
            r_cfg.camera_limit <= lfps_pkg::LIMIT_RST;
        end else if (w_wr) begin
            case (w_idx)
                lfps_pkg::REG_PROP:  r_cfg.prop_gain    <= pwdata[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::REG_INTEG: r_cfg.integ_gain   <= pwdata[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::REG_DERIV: r_cfg.deriv_gain   <= pwdata[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::REG_FAST:  r_cfg.fast_speed   <= pwdata[lfps_pkg::SPD_W-1:0];
                lfps_pkg::REG_SLOW:  r_cfg.slow_speed   <= pwdata[lfps_pkg::SPD_W-1:0];
                lfps_pkg::REG_LIMIT: r_cfg.camera_limit <= pwdata[lfps_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register, zero extended
    always_comb begin
        case (w_idx)
            lfps_pkg::REG_PROP:  prdata = lfps_pkg::DATA_W'(r_cfg.prop_gain);
            lfps_pkg::REG_INTEG: prdata = lfps_pkg::DATA_W'(r_cfg.integ_gain);
            lfps_pkg::REG_DERIV: prdata = lfps_pkg::DATA_W'(r_cfg.deriv_gain);
            lfps_pkg::REG_FAST:  prdata = lfps_pkg::DATA_W'(r_cfg.fast_speed);
            lfps_pkg::REG_SLOW:  prdata = lfps_pkg::DATA_W'(r_cfg.slow_speed);
            lfps_pkg::REG_LIMIT: prdata = lfps_pkg::DATA_W'(r_cfg.camera_limit);
            default:             prdata = '0;
        endcase
    end

endmodule

FILE: hdl/lfps_pos.sv
// Line position unit: serial sensor scan, then a bit-serial rounding divider.
module lfps_pos #(
    parameter int SENSOR_COUNT = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lfps_pkg::SENS_W-1:0] i_sensor_bits,
    output lfps_pkg::t_pos_stat         o_stat
);

    localparam int SCAN_N = (SENSOR_COUNT < lfps_pkg::SENS_W) ? SENSOR_COUNT
                                                               : lfps_pkg::SENS_W;
    localparam int SC_W = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
    localparam logic [SC_W-1:0] SC_LAST = SC_W'(SCAN_N - 1);
    localparam logic signed [lfps_pkg::WGT_W-1:0] WGT_FIRST =
        lfps_pkg::WGT_W'(1 - SENSOR_COUNT);

    lfps_pkg::t_pos_phase r_phase, n_phase;

    logic [lfps_pkg::SENS_W-1:0]        r_bits;
    logic [SC_W-1:0]                    r_idx;
    logic signed [lfps_pkg::WGT_W-1:0]  r_wgt;
    logic signed [lfps_pkg::HS_W-1:0]   r_hs;
    logic [lfps_pkg::CNT_W-1:0]         r_cnt;
    logic                               r_neg;
    logic [lfps_pkg::DIV_W-1:0]         r_num;
    logic [lfps_pkg::REM_W-1:0]         r_rem;
    logic [lfps_pkg::DIV_W-1:0]         r_q;
    logic [lfps_pkg::DIV_CW-1:0]        r_dcnt;

    logic [lfps_pkg::HS_W-1:0]          w_mag;
    logic [lfps_pkg::DIV_W-1:0]         w_num;
    logic [lfps_pkg::REM_W-1:0]         w_den;
    logic [lfps_pkg::REM_W:0]           w_trial;
    logic                               w_fit;
    logic [lfps_pkg::POS_W-1:0]         w_qmag;

    // Advance the phase
    always_comb begin
        case (r_phase)
            lfps_pkg::PH_IDLE: n_phase = i_start ? lfps_pkg::PH_SCAN : lfps_pkg::PH_IDLE;
            lfps_pkg::PH_SCAN: n_phase = (r_idx == SC_LAST) ? lfps_pkg::PH_PREP
                                                            : lfps_pkg::PH_SCAN;
            lfps_pkg::PH_PREP: n_phase = (r_cnt == '0) ? lfps_pkg::PH_DONE
                                                       : lfps_pkg::PH_DIV;
            lfps_pkg::PH_DIV:  n_phase = (r_dcnt == lfps_pkg::DIV_LAST) ? lfps_pkg::PH_DONE
                                                                       : lfps_pkg::PH_DIV;
            lfps_pkg::PH_DONE: n_phase = lfps_pkg::PH_IDLE;
            default:           n_phase = lfps_pkg::PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lfps_pkg::PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Dividend 2*|sum|*128 + count, divisor 2*count: round half away from zero
    assign w_mag   = r_hs[lfps_pkg::HS_W-1] ? lfps_pkg::HS_W'(-r_hs)
                                            : lfps_pkg::HS_W'(r_hs);
    assign w_num   = {w_mag[lfps_pkg::HS_W-2:0], 8'h00}
                   + lfps_pkg::DIV_W'(r_cnt);
    assign w_den   = {r_cnt, 1'b0};
    assign w_trial = {r_rem, r_num[lfps_pkg::DIV_W-1]};
    assign w_fit   = (w_trial >= {1'b0, w_den});

    // Scan one sensor a cycle, then one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        case (r_phase)
            lfps_pkg::PH_IDLE: begin
                if (i_start) begin
                    r_bits <= i_sensor_bits;
                    r_idx  <= '0;
                    r_wgt  <= WGT_FIRST;
                    r_hs   <= '0;
                    r_cnt  <= '0;
                end
            end
            lfps_pkg::PH_SCAN: begin
                if (r_bits[0]) begin
                    r_hs  <= r_hs + {{(lfps_pkg::HS_W - lfps_pkg::WGT_W){r_wgt[lfps_pkg::WGT_W-1]}},
                                     r_wgt};
                    r_cnt <= r_cnt + 1'b1;
                end
                r_wgt  <= r_wgt + lfps_pkg::WGT_W'(2);
                r_bits <= {1'b0, r_bits[lfps_pkg::SENS_W-1:1]};
                r_idx  <= r_idx + 1'b1;
            end
            lfps_pkg::PH_PREP: begin
                r_neg  <= r_hs[lfps_pkg::HS_W-1];
                r_num  <= w_num;
                r_rem  <= '0;
                r_q    <= '0;
                r_dcnt <= '0;
            end
            lfps_pkg::PH_DIV: begin
                r_rem  <= w_fit ? lfps_pkg::REM_W'(w_trial - {1'b0, w_den})
                                : w_trial[lfps_pkg::REM_W-1:0];
                r_q    <= {r_q[lfps_pkg::DIV_W-2:0], w_fit};
                r_num  <= {r_num[lfps_pkg::DIV_W-2:0], 1'b0};
                r_dcnt <= r_dcnt + 1'b1;
            end
            default: ;
        endcase
    end

    // Apply the sign to the rounded magnitude
    assign w_qmag      = r_q[lfps_pkg::POS_W-1:0];
    assign o_stat.done = (r_phase == lfps_pkg::PH_DONE);
    assign o_stat.seen = (r_cnt != '0);
    assign o_stat.pos  = r_neg ? -w_qmag : w_qmag;

endmodule

FILE: hdl/lfps_mac.sv
// Bit-serial multiply-accumulate of the three PID terms, one gain bit per cycle.
module lfps_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  lfps_pkg::t_cfg                     i_cfg,
    input  logic signed [lfps_pkg::POS_W-1:0]  i_pos,
    input  logic signed [lfps_pkg::INT_W-1:0]  i_integ,
    input  logic signed [lfps_pkg::DLT_W-1:0]  i_delta,
    output logic                               o_done,
    output logic signed [lfps_pkg::ACC_W-1:0]  o_acc
);

    localparam int TW = lfps_pkg::TERM_W;
    localparam int GT = lfps_pkg::GAIN_W - 1;

    logic                              r_busy;
    logic [lfps_pkg::MAC_CW-1:0]       r_step;
    logic [lfps_pkg::GAIN_W-1:0]       r_kp;
    logic [lfps_pkg::GAIN_W-1:0]       r_ki;
    logic [lfps_pkg::GAIN_W-1:0]       r_kd;
    logic signed [TW-1:0]              r_term;
    logic signed [lfps_pkg::ACC_W-1:0] r_acc;

    logic [TW-1:0] w_tp;
    logic [TW-1:0] w_ti;
    logic [TW-1:0] w_td;
    logic [TW-1:0] w_term;

    // Select each multiplicand by the current gain bit
    assign w_tp = r_kp[GT] ? {{(TW - lfps_pkg::POS_W){i_pos[lfps_pkg::POS_W-1]}}, i_pos}
                           : '0;
    assign w_ti = r_ki[GT] ? {{(TW - lfps_pkg::INT_W){i_integ[lfps_pkg::INT_W-1]}}, i_integ}
                           : '0;
    assign w_td = r_kd[GT] ? {{(TW - lfps_pkg::DLT_W){i_delta[lfps_pkg::DLT_W-1]}}, i_delta}
                           : '0;
    assign w_term = w_tp + w_ti + w_td;

    assign o_done = r_busy && (r_step == lfps_pkg::MAC_LAST);
    assign o_acc  = r_acc;

    // Track the step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_busy <= !o_done;
            r_step <= r_step + 1'b1;
        end
    end

    // Shift the gains out MSB first and fold each term into the accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_kp   <= i_cfg.prop_gain;
            r_ki   <= i_cfg.integ_gain;
            r_kd   <= i_cfg.deriv_gain;
            r_term <= '0;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_kp   <= {r_kp[GT-1:0], 1'b0};
            r_ki   <= {r_ki[GT-1:0], 1'b0};
            r_kd   <= {r_kd[GT-1:0], 1'b0};
            r_term <= w_term;
            r_acc  <= (r_acc <<< 1)
                    + {{(lfps_pkg::ACC_W - TW){r_term[TW-1]}}, r_term};
        end
    end

endmodule

FILE: hdl/lfps_chk.sv
// Port checker for the line-follow PID steering block, bound to the top level.
module lfps_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [lfps_pkg::DIR_W-1:0]         o_drive_dir,
    input logic signed [lfps_pkg::OUT_W-1:0]  o_left_speed,
    input logic signed [lfps_pkg::OUT_W-1:0]  o_right_speed,
    input logic                               o_line_seen
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid
            && $stable({o_drive_dir, o_left_speed, o_right_speed, o_line_seen}))
        else $error("stalled result word changed");

    // Stay busy right after taking a word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again without work in between");

    // Rotate at corner speed when the line is lost
    a_no_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_line_seen |->
            (o_drive_dir == lfps_pkg::DIR_LEFT || o_drive_dir == lfps_pkg::DIR_RIGHT)
            && o_left_speed == lfps_pkg::CORNER_SPEED
            && o_right_speed == lfps_pkg::CORNER_SPEED)
        else $error("bad result word with no line");

    // Drive forward within the speed limits when the line is seen
    a_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_seen |-> o_drive_dir == lfps_pkg::DIR_FWD
            && o_left_speed >= lfps_pkg::SPD_NEG_MAX
            && o_right_speed >= lfps_pkg::SPD_NEG_MAX)
        else $error("bad result word with line seen");

endmodule

bind line_follow_pid_steering lfps_chk u_lfps_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_drive_dir   (o_drive_dir),
    .o_left_speed  (o_left_speed),
    .o_right_speed (o_right_speed),
    .o_line_seen   (o_line_seen)
);

FILE: tb/sv/line_follow_pid_steering_tb.sv
// Self-checking testbench for the line-follow PID steering block.
`timescale 1ns / 100ps

module line_follow_pid_steering_tb;

    localparam int SENSORS      = 8;
    localparam int PHASES       = 7;
    localparam int RAND_WORDS   = 76;
    localparam int PAUSE_AT     = 40;
    localparam int SETTLE       = 8;
    localparam int TAIL_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DIRECTED_N   = 25;

    // One steering command as seen on the result channel
    typedef struct packed {
        logic [lfps_pkg::DIR_W-1:0]        dir;
        logic signed [lfps_pkg::OUT_W-1:0] left_spd;
        logic signed [lfps_pkg::OUT_W-1:0] right_spd;
        logic                              line;
    } t_steer;

    // One directed stimulus row, with an optional hand-written command
    typedef struct packed {
        logic [lfps_pkg::SENS_W-1:0]       bits;
        logic signed [lfps_pkg::CAM_W-1:0] cam;
        logic                              cam_ok;
        logic                              fixed;
        t_steer                            want;
    } t_dir_row;

    localparam t_steer SPIN_LEFT  = '{dir: lfps_pkg::DIR_LEFT,
                                      left_spd: lfps_pkg::CORNER_SPEED,
                                      right_spd: lfps_pkg::CORNER_SPEED, line: 1'b0};
    localparam t_steer SPIN_RIGHT = '{dir: lfps_pkg::DIR_RIGHT,
                                      left_spd: lfps_pkg::CORNER_SPEED,
                                      right_spd: lfps_pkg::CORNER_SPEED, line: 1'b0};
    localparam t_steer NONE       = '0;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic [lfps_pkg::SENS_W-1:0]         i_sensor_bits = '0;
    logic signed [lfps_pkg::CAM_W-1:0]   i_camera_error = '0;
    logic                                i_camera_ok = 1'b0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic [lfps_pkg::DIR_W-1:0]          o_drive_dir;
    logic signed [lfps_pkg::OUT_W-1:0]   o_left_speed;
    logic signed [lfps_pkg::OUT_W-1:0]   o_right_speed;
    logic                                o_line_seen;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [lfps_pkg::ADDR_W-1:0]         paddr = '0;
    logic [lfps_pkg::DATA_W-1:0]         pwdata = '0;
    logic [lfps_pkg::DATA_W-1:0]         prdata;
    logic                                pready;

    // Steering model state and register copy
    lfps_pkg::t_cfg            gains = '{prop_gain: lfps_pkg::PROP_RST,
                                         integ_gain: lfps_pkg::INTEG_RST,
                                         deriv_gain: lfps_pkg::DERIV_RST,
                                         fast_speed: lfps_pkg::FAST_RST,
                                         slow_speed: lfps_pkg::SLOW_RST,
                                         camera_limit: lfps_pkg::LIMIT_RST};
    longint                    integ_acc = 0;
    int                        prev_pos = 0;
    logic [1:0]                line_side = lfps_pkg::SIDE_CTR;

    t_steer                    steer_q[$];
    bit                        quiet = 1'b0;
    int                        fault_count = 0;
    int                        words_sent = 0;
    int                        no_line_words = 0;
    int                        cmds_checked = 0;
    int                        cycle_count = 0;

    line_follow_pid_steering #(.SENSOR_COUNT(SENSORS)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sensor_bits  (i_sensor_bits),
        .i_camera_error (i_camera_error),
        .i_camera_ok    (i_camera_ok),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_drive_dir    (o_drive_dir),
        .o_left_speed   (o_left_speed),
        .o_right_speed  (o_right_speed),
        .o_line_seen    (o_line_seen),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles", $time, cycle_count);
            $display("line_follow_pid_steering_tb: errors");
            $finish;
        end
    end

    // Round a Q.16 wheel value to the nearest step and clamp to the speed range
    function automatic logic signed [lfps_pkg::OUT_W-1:0] wheel_cmd(input longint q16);
        longint w;
        w = (q16 + 64'sd32768) >>> 16;
        if (w > 255)
            w = 255;
        if (w < -255)
            w = -255;
        return w[lfps_pkg::OUT_W-1:0];
    endfunction

    // Work out the steering command for one word and advance the PID state
    function automatic t_steer predict_steer(input logic [lfps_pkg::SENS_W-1:0] bits,
                                             input logic signed [lfps_pkg::CAM_W-1:0] cam,
                                             input logic cam_ok);
        int     half_sum;
        int     hits;
        int     num;
        int     mag;
        int     pos;
        int     cam_v;
        int     lim;
        longint kp;
        longint ki;
        longint kd;
        longint corr;
        longint base;
        t_steer r;
        half_sum = 0;
        hits = 0;
        for (int i = 0; i < SENSORS && i < lfps_pkg::SENS_W; i++) begin
            if (bits[i]) begin
                half_sum += 2 * i - (SENSORS - 1);
                hits++;
            end
        end
        // No line: spin toward the side it was last seen on
        if (hits == 0)
            return (line_side == lfps_pkg::SIDE_LEFT) ? SPIN_LEFT : SPIN_RIGHT;
        // Mean position in Q.8, ties away from zero
        num = half_sum * 128;
        mag = (num < 0) ? -num : num;
        pos = (2 * mag + hits) / (2 * hits);
        if (num < 0)
            pos = -pos;
        if (pos < 0)
            line_side = lfps_pkg::SIDE_LEFT;
        else if (pos > 0)
            line_side = lfps_pkg::SIDE_RIGHT;
        else
            line_side = lfps_pkg::SIDE_CTR;
        integ_acc += pos;
        if (integ_acc > 64'sd2147483647)
            integ_acc = 64'sd2147483647;
        if (integ_acc < -64'sd2147483648)
            integ_acc = -64'sd2147483648;
        kp = gains.prop_gain;
        ki = gains.integ_gain;
        kd = gains.deriv_gain;
        corr = -(kp * pos + ki * integ_acc + kd * (pos - prev_pos));
        prev_pos = pos;
        // Fast only on a valid camera error strictly inside the limit
        cam_v = cam;
        lim = gains.camera_limit;
        if (cam_ok && cam_v < lim && cam_v > -lim)
            base = gains.fast_speed;
        else
            base = gains.slow_speed;
        r.dir = lfps_pkg::DIR_FWD;
        r.left_spd = wheel_cmd(base * 65536 + corr);
        r.right_spd = wheel_cmd(base * 65536 - corr);
        r.line = 1'b1;
        return r;
    endfunction

    // Register write: setup phase, access phase, then return to idle
    task automatic reg_write(input logic [lfps_pkg::IDX_W-1:0] idx,
                             input logic [lfps_pkg::DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Program every register and mirror it in the model
    task automatic load_gains(input lfps_pkg::t_cfg c);
        reg_write(lfps_pkg::REG_PROP, lfps_pkg::DATA_W'(c.prop_gain));
        reg_write(lfps_pkg::REG_INTEG, lfps_pkg::DATA_W'(c.integ_gain));
        reg_write(lfps_pkg::REG_DERIV, lfps_pkg::DATA_W'(c.deriv_gain));
        reg_write(lfps_pkg::REG_FAST, lfps_pkg::DATA_W'(c.fast_speed));
        reg_write(lfps_pkg::REG_SLOW, lfps_pkg::DATA_W'(c.slow_speed));
        reg_write(lfps_pkg::REG_LIMIT, lfps_pkg::DATA_W'(c.camera_limit));
        gains = c;
    endtask

    // Hold the sender until every command is back
    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (steer_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Offer one sensor word and record its expected command once taken
    task automatic send_word(input logic [lfps_pkg::SENS_W-1:0] bits,
                             input logic signed [lfps_pkg::CAM_W-1:0] cam,
                             input logic cam_ok, input logic fixed, input t_steer want);
        int     gap;
        t_steer pred;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sensor_bits <= bits;
        i_camera_error <= cam;
        i_camera_ok <= cam_ok;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pred = predict_steer(bits, cam, cam_ok);
        steer_q.push_back(fixed ? want : pred);
        words_sent++;
        if (bits == '0)
            no_line_words++;
    endtask

    // Register settings per phase; phase 0 keeps the reset values
    function automatic lfps_pkg::t_cfg phase_gains(input int p);
        lfps_pkg::t_cfg c;
        c = gains;
        case (p)
            1: c = '{prop_gain: 24'd256, integ_gain: 24'd1, deriv_gain: 24'd128,
                     fast_speed: 8'd200, slow_speed: 8'd100, camera_limit: 15'd1000};
            2: c = '{prop_gain: '0, integ_gain: '0, deriv_gain: '0,
                     fast_speed: 8'd255, slow_speed: 8'd0, camera_limit: '0};
            3: c = '{prop_gain: '1, integ_gain: '1, deriv_gain: '1,
                     fast_speed: 8'd0, slow_speed: 8'd255, camera_limit: '1};
            4: c = '{prop_gain: lfps_pkg::GAIN_W'($urandom),
                     integ_gain: lfps_pkg::GAIN_W'($urandom),
                     deriv_gain: lfps_pkg::GAIN_W'($urandom),
                     fast_speed: lfps_pkg::SPD_W'($urandom),
                     slow_speed: lfps_pkg::SPD_W'($urandom),
                     camera_limit: lfps_pkg::LIM_W'($urandom)};
            5: c = '{prop_gain: lfps_pkg::GAIN_W'($urandom_range(0, 1023)),
                     integ_gain: lfps_pkg::GAIN_W'($urandom_range(0, 7)),
                     deriv_gain: lfps_pkg::GAIN_W'($urandom_range(0, 1023)),
                     fast_speed: lfps_pkg::SPD_W'($urandom_range(60, 140)),
                     slow_speed: lfps_pkg::SPD_W'($urandom_range(20, 80)),
                     camera_limit: lfps_pkg::LIM_W'($urandom_range(0, 200))};
            6: c = '{prop_gain: lfps_pkg::PROP_RST, integ_gain: lfps_pkg::INTEG_RST,
                     deriv_gain: lfps_pkg::DERIV_RST, fast_speed: lfps_pkg::FAST_RST,
                     slow_speed: lfps_pkg::SLOW_RST, camera_limit: '1};
            default: ;
        endcase
        return c;
    endfunction

    // Result side: random stalls, compare each command against the oldest expectation
    initial begin : result_sink
        int     hold;
        t_steer got;
        t_steer want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid === 1'b1 && i_stall === 1'b0));
            got.dir = o_drive_dir;
            got.left_spd = o_left_speed;
            got.right_spd = o_right_speed;
            got.line = o_line_seen;
            if (steer_q.size() == 0) begin
                $display("%0t: unexpected command dir=%0d left=%0d right=%0d seen=%0d",
                         $time, got.dir, $signed(got.left_spd), $signed(got.right_spd),
                         got.line);
                fault_count++;
            end else begin
                want = steer_q.pop_front();
                if (got.dir !== want.dir || got.left_spd !== want.left_spd ||
                    got.right_spd !== want.right_spd || got.line !== want.line) begin
                    $display({"%0t: command %0d expected dir=%0d left=%0d right=%0d ",
                              "seen=%0d, got dir=%0d left=%0d right=%0d seen=%0d"},
                             $time, cmds_checked, want.dir, $signed(want.left_spd),
                             $signed(want.right_spd), want.line, got.dir,
                             $signed(got.left_spd), $signed(got.right_spd), got.line);
                    fault_count++;
                end
            end
            cmds_checked++;
        end
    end

    // Stimulus: directed rows at reset settings, then random phases
    initial begin : stimulus
        t_dir_row                    rows [DIRECTED_N];
        logic [lfps_pkg::SENS_W-1:0] bits;
        logic [lfps_pkg::CAM_W-1:0]  cam;
        logic                        cam_ok;
        int                          run_len;
        int                          near;
        rows = '{
            '{8'h00, 16'sd0,      1'b1, 1'b1, SPIN_RIGHT},  // centre after reset
            '{8'h01, 16'sd0,      1'b1, 1'b0, NONE},        // far left sensor
            '{8'h00, 16'sd0,      1'b0, 1'b1, SPIN_LEFT},
            '{8'h80, 16'sh7FFF,   1'b1, 1'b0, NONE},        // far right sensor
            '{8'h00, 16'sh8000,   1'b1, 1'b1, SPIN_RIGHT},
            '{8'h18, 16'sd29,     1'b1, 1'b0, NONE},        // centred, inside limit
            '{8'h00, 16'sd30,     1'b1, 1'b1, SPIN_RIGHT},  // centre spins right
            '{8'hFF, -16'sd29,    1'b1, 1'b0, NONE},
            '{8'hFF, -16'sd30,    1'b1, 1'b0, NONE},        // on the limit
            '{8'h03, 16'sd30,     1'b0, 1'b0, NONE},        // camera ignored
            '{8'h00, -16'sd1,     1'b1, 1'b1, SPIN_LEFT},
            '{8'h07, 16'sd0,      1'b1, 1'b0, NONE},
            '{8'h0B, -16'sd31,    1'b1, 1'b0, NONE},        // rounded mean
            '{8'h81, 16'sd31,     1'b1, 1'b0, NONE},
            '{8'h00, 16'sd0,      1'b0, 1'b1, SPIN_RIGHT},
            '{8'h40, 16'sh7FFF,   1'b0, 1'b0, NONE},
            '{8'h7F, 16'sh8000,   1'b0, 1'b0, NONE},
            '{8'hFE, 16'sd1,      1'b1, 1'b0, NONE},
            '{8'h00, 16'sd0,      1'b1, 1'b1, SPIN_RIGHT},
            '{8'hAA, 16'sd12345,  1'b1, 1'b0, NONE},
            '{8'h55, -16'sd12345, 1'b1, 1'b0, NONE},
            '{8'h00, 16'sd5,      1'b1, 1'b1, SPIN_LEFT},
            '{8'h3C, 16'sd0,      1'b1, 1'b0, NONE},
            '{8'hC0, 16'sd3,      1'b1, 1'b0, NONE},
            '{8'h00, 16'sd0,      1'b1, 1'b1, SPIN_RIGHT}
        };

        // Hold reset, then release it
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_N; r++)
            send_word(rows[r].bits, rows[r].cam, rows[r].cam_ok, rows[r].fixed, rows[r].want);

        for (int p = 0; p < PHASES; p++) begin
            wait_drain();
            if (p > 0)
                load_gains(phase_gains(p));
            // Phases 3 and 5 send words back to back, with no idling on either side
            quiet = (p == 3 || p == 5);
            for (int k = 0; k < RAND_WORDS; k++) begin
                if (k == PAUSE_AT)
                    wait_drain();
                // Mostly short runs of adjacent sensors, some noise and lost line
                case ($urandom_range(0, 9))
                    0: bits = '0;
                    1, 2, 3, 4, 5: begin
                        run_len = $urandom_range(1, 3);
                        bits = lfps_pkg::SENS_W'(((1 << run_len) - 1)
                               << $urandom_range(0, lfps_pkg::SENS_W - run_len));
                    end
                    default: bits = lfps_pkg::SENS_W'($urandom);
                endcase
                // Camera error around the limit, at the extremes, or anywhere
                case ($urandom_range(0, 5))
                    0: cam = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    1, 2: begin
                        near = int'(gains.camera_limit) + int'($urandom_range(0, 4)) - 2;
                        if ($urandom_range(0, 1))
                            near = -near;
                        cam = near[lfps_pkg::CAM_W-1:0];
                    end
                    default: cam = lfps_pkg::CAM_W'($urandom);
                endcase
                cam_ok = ($urandom_range(0, 4) != 0);
                send_word(bits, cam, cam_ok, 1'b0, NONE);
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d steering commands for %0d sensor words (%0d with the line lost)",
                 cmds_checked, words_sent, no_line_words);
        $display("across %0d register settings incl. zero and full-scale gains and limits",
                 PHASES);
        if (fault_count == 0 && steer_q.size() == 0) begin
            $display("line_follow_pid_steering_tb: clean");
        end else begin
            $display("%0t: %0d mismatches, %0d commands still outstanding",
                     $time, fault_count, steer_q.size());
            $display("line_follow_pid_steering_tb: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/lfps_pkg.sv
hdl/lfps_regs.sv
hdl/lfps_pos.sv
hdl/lfps_mac.sv
hdl/line_follow_pid_steering.sv
hdl/lfps_chk.sv
tb/sv/line_follow_pid_steering_tb.sv
